FILE: rtl/tcsg_pkg.sv
// Shared types, field widths, codes and the microcode program of the wall column span generator.
// Used by tcsg_sequencer and textured_column_span_generator_core; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package tcsg_pkg;

    // Field and register widths fixed by the interface.
    localparam int COLOUR_W = 32;
    localparam int ROWS_W   = 12;
    localparam int HOR_W    = 11;
    localparam int H_W      = 11;
    localparam int SPAN_W   = 13;
    localparam int TROW_W   = 10;
    localparam int TCOL_W   = 10;
    localparam int SRC_W    = 2;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 5;
    localparam int IDX_W    = 3;

    // Internal arithmetic widths.
    localparam int TEX_MAX  = 1024;
    localparam int DIVR_W   = 13;
    localparam int FAC_W    = 15;
    localparam int MAG_W    = 14;
    localparam int CLS_W    = 15;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_CEILING    = 3'd0;
    localparam logic [IDX_W-1:0] REG_FLOOR      = 3'd1;
    localparam logic [IDX_W-1:0] REG_PLAIN      = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROWS       = 3'd3;
    localparam logic [IDX_W-1:0] REG_HORIZON    = 3'd4;
    localparam logic [IDX_W-1:0] REG_TEX_HEIGHT = 3'd5;

    // Item kinds and pixel sources.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    localparam logic [SRC_W-1:0] SRC_CEILING = 2'd0;
    localparam logic [SRC_W-1:0] SRC_TEXTURE = 2'd1;
    localparam logic [SRC_W-1:0] SRC_PLAIN   = 2'd2;
    localparam logic [SRC_W-1:0] SRC_FLOOR   = 2'd3;

    // Microcode fields.
    localparam int UPC_W = 4;
    localparam int OP_W  = 4;
    localparam int CND_W = 4;

    localparam logic [OP_W-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_W-1:0] OP_ACCEPT   = 4'd1;
    localparam logic [OP_W-1:0] OP_DIV_LOAD = 4'd2;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 4'd3;
    localparam logic [OP_W-1:0] OP_MUL_LOAD = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_STEP = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_FIX  = 4'd6;
    localparam logic [OP_W-1:0] OP_CLEAR    = 4'd7;
    localparam logic [OP_W-1:0] OP_MOD_LOAD = 4'd8;
    localparam logic [OP_W-1:0] OP_MOD_STEP = 4'd9;
    localparam logic [OP_W-1:0] OP_EMIT     = 4'd10;

    localparam logic [CND_W-1:0] C_NEVER    = 4'd0;
    localparam logic [CND_W-1:0] C_ALWAYS   = 4'd1;
    localparam logic [CND_W-1:0] C_NO_BEAT  = 4'd2;
    localparam logic [CND_W-1:0] C_PIXEL    = 4'd3;
    localparam logic [CND_W-1:0] C_NO_SPAN  = 4'd4;
    localparam logic [CND_W-1:0] C_MORE     = 4'd5;
    localparam logic [CND_W-1:0] C_IDLE_COL = 4'd6;
    localparam logic [CND_W-1:0] C_NO_FETCH = 4'd7;
    localparam logic [CND_W-1:0] C_OUT_BUSY = 4'd8;

    // Program addresses.
    localparam logic [UPC_W-1:0] A_IDLE     = 4'd0;
    localparam logic [UPC_W-1:0] A_DISPATCH = 4'd1;
    localparam logic [UPC_W-1:0] A_START    = 4'd2;
    localparam logic [UPC_W-1:0] A_DIV      = 4'd3;
    localparam logic [UPC_W-1:0] A_MUL_LD   = 4'd4;
    localparam logic [UPC_W-1:0] A_MUL      = 4'd5;
    localparam logic [UPC_W-1:0] A_MUL_FIX  = 4'd6;
    localparam logic [UPC_W-1:0] A_ZERO     = 4'd7;
    localparam logic [UPC_W-1:0] A_PIX      = 4'd8;
    localparam logic [UPC_W-1:0] A_MOD_LD   = 4'd9;
    localparam logic [UPC_W-1:0] A_MOD      = 4'd10;
    localparam logic [UPC_W-1:0] A_EMIT     = 4'd11;
    localparam logic [UPC_W-1:0] A_DONE     = 4'd12;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CND_W-1:0] cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic no_beat;
        logic pixel;
        logic no_span;
        logic more;
        logic idle_col;
        logic no_fetch;
        logic out_busy;
    } flags_t;

    // The program. A step jumps to its target when its condition holds, else falls through.
    function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
        uword_t w;
        case (addr)
            A_IDLE:     w = '{op: OP_ACCEPT,   cond: C_NO_BEAT,  target: A_IDLE};
            A_DISPATCH: w = '{op: OP_NOP,      cond: C_PIXEL,    target: A_PIX};
            A_START:    w = '{op: OP_DIV_LOAD, cond: C_NO_SPAN,  target: A_ZERO};
            A_DIV:      w = '{op: OP_DIV_STEP, cond: C_MORE,     target: A_DIV};
            A_MUL_LD:   w = '{op: OP_MUL_LOAD, cond: C_NEVER,    target: A_IDLE};
            A_MUL:      w = '{op: OP_MUL_STEP, cond: C_MORE,     target: A_MUL};
            A_MUL_FIX:  w = '{op: OP_MUL_FIX,  cond: C_ALWAYS,   target: A_IDLE};
            A_ZERO:     w = '{op: OP_CLEAR,    cond: C_ALWAYS,   target: A_IDLE};
            A_PIX:      w = '{op: OP_NOP,      cond: C_IDLE_COL, target: A_IDLE};
            A_MOD_LD:   w = '{op: OP_MOD_LOAD, cond: C_NO_FETCH, target: A_EMIT};
            A_MOD:      w = '{op: OP_MOD_STEP, cond: C_MORE,     target: A_MOD};
            A_EMIT:     w = '{op: OP_EMIT,     cond: C_OUT_BUSY, target: A_EMIT};
            A_DONE:     w = '{op: OP_NOP,      cond: C_ALWAYS,   target: A_IDLE};
            default:    w = '{op: OP_NOP,      cond: C_ALWAYS,   target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tcsg_sequencer.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on tcsg_pkg for the control word, the condition flags and the program.
`timescale 1ns / 1ps
`default_nettype none

module tcsg_sequencer (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire tcsg_pkg::flags_t flags,
    output tcsg_pkg::uword_t     uword
);

    logic [tcsg_pkg::UPC_W-1:0] upc_reg;
    logic [tcsg_pkg::UPC_W-1:0] upc_next;
    logic                       jump;

    assign uword = tcsg_pkg::ucode(upc_reg);

    always_comb begin
        case (uword.cond)
            tcsg_pkg::C_NEVER:    jump = 1'b0;
            tcsg_pkg::C_ALWAYS:   jump = 1'b1;
            tcsg_pkg::C_NO_BEAT:  jump = flags.no_beat;
            tcsg_pkg::C_PIXEL:    jump = flags.pixel;
            tcsg_pkg::C_NO_SPAN:  jump = flags.no_span;
            tcsg_pkg::C_MORE:     jump = flags.more;
            tcsg_pkg::C_IDLE_COL: jump = flags.idle_col;
            tcsg_pkg::C_NO_FETCH: jump = flags.no_fetch;
            tcsg_pkg::C_OUT_BUSY: jump = flags.out_busy;
            default:              jump = 1'b1;
        endcase
        upc_next = jump ? uword.target : upc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= tcsg_pkg::A_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/textured_column_span_generator_core.sv
// Top level of the wall column span generator: APB registers, datapath and output register.
// Depends on tcsg_pkg and tcsg_sequencer.
`timescale 1ns / 1ps
`default_nettype none

// A start beat loads one screen column and computes the texture step and start position
// with a bit-serial divider and a shift-add multiplier, in FRAC_BITS + 11 divide iterations
// and 14 multiply iterations, both skipped when the wall span is empty or the texture
// height is zero. Each pixel beat then yields one output beat for the next row; textured
// wall rows first run 25 remainder iterations to produce the texel row. A pixel beat with
// no column loaded yields nothing. Only one beat is in work at a time; a finished pixel
// waits in the output register while m_ready stays low.
module textured_column_span_generator_core #(
    parameter int ROW_BITS  = 11,
    parameter int COL_BITS  = 11,
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tcsg_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [tcsg_pkg::DATA_W-1:0]          pwdata,
    output logic      [tcsg_pkg::DATA_W-1:0]          prdata,
    output logic                                      pready,

    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_kind,
    input  wire logic [COL_BITS-1:0]                  s_column,
    input  wire logic signed [tcsg_pkg::SPAN_W-1:0]   s_wall_top,
    input  wire logic signed [tcsg_pkg::SPAN_W-1:0]   s_wall_bottom,
    input  wire logic [tcsg_pkg::TCOL_W-1:0]          s_texture_column,
    input  wire logic                                 s_textured,

    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic      [COL_BITS-1:0]                  m_pixel_column,
    output logic      [ROW_BITS-1:0]                  m_pixel_row,
    output logic      [tcsg_pkg::SRC_W-1:0]           m_source,
    output logic      [tcsg_pkg::COLOUR_W-1:0]        m_colour,
    output logic      [tcsg_pkg::TROW_W-1:0]          m_texel_row,
    output logic      [tcsg_pkg::TCOL_W-1:0]          m_texel_column,
    output logic                                      m_last
);

    localparam int STEP_W = FRAC_BITS + tcsg_pkg::H_W;
    localparam int POS_W  = STEP_W + tcsg_pkg::FAC_W;
    localparam int TI_W   = POS_W - 1 - FRAC_BITS;
    localparam int SH_W   = (STEP_W > TI_W) ? STEP_W : TI_W;
    localparam int CNT_W  = $clog2(SH_W + 1);
    localparam int RW     = (ROW_BITS + 1 > tcsg_pkg::ROWS_W) ? ROW_BITS + 1 : tcsg_pkg::ROWS_W;

    // Configuration registers.
    logic [tcsg_pkg::COLOUR_W-1:0] ceiling_reg, floor_reg, plain_reg;
    logic [tcsg_pkg::ROWS_W-1:0]   rows_reg;
    logic [tcsg_pkg::HOR_W-1:0]    horizon_reg;
    logic [tcsg_pkg::H_W-1:0]      tex_height_reg;
    logic                          cfg_write;
    logic [tcsg_pkg::IDX_W-1:0]    cfg_index;

    // Column state.
    logic                               active_reg, active_next;
    logic [ROW_BITS-1:0]                row_reg, row_next;
    logic                               kind_reg, kind_next;
    logic [COL_BITS-1:0]                column_reg, column_next;
    logic signed [tcsg_pkg::SPAN_W-1:0] top_reg, top_next;
    logic signed [tcsg_pkg::SPAN_W-1:0] bottom_reg, bottom_next;
    logic [tcsg_pkg::TCOL_W-1:0]        texcol_reg, texcol_next;
    logic                               textured_reg, textured_next;
    logic [STEP_W-1:0]                  step_reg, step_next;
    logic signed [POS_W-1:0]            pos_reg, pos_next;

    // Shared shift-subtract and shift-add unit.
    logic [SH_W-1:0]                    shift_reg, shift_next;
    logic [tcsg_pkg::DIVR_W-1:0]        rem_reg, rem_next;
    logic [tcsg_pkg::DIVR_W-1:0]        divisor_reg, divisor_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               neg_reg, neg_next;

    // Output register.
    logic                               m_valid_reg, m_valid_next;
    logic [COL_BITS-1:0]                m_column_reg, m_column_next;
    logic [ROW_BITS-1:0]                m_row_reg, m_row_next;
    logic [tcsg_pkg::SRC_W-1:0]         m_source_reg, m_source_next;
    logic [tcsg_pkg::COLOUR_W-1:0]      m_colour_reg, m_colour_next;
    logic [tcsg_pkg::TROW_W-1:0]        m_trow_reg, m_trow_next;
    logic [tcsg_pkg::TCOL_W-1:0]        m_tcol_reg, m_tcol_next;
    logic                               m_last_reg, m_last_next;

    // Derived values.
    tcsg_pkg::uword_t                   uword;
    tcsg_pkg::flags_t                   flags;
    logic [tcsg_pkg::H_W-1:0]           h_eff;
    logic [RW-1:0]                      rows_raw, rows_lim, rows_eff;
    logic                               last_row;
    logic signed [tcsg_pkg::SPAN_W:0]   span;
    logic                               span_pos;
    logic signed [tcsg_pkg::FAC_W-1:0]  top_clip, fac;
    logic [tcsg_pkg::FAC_W-1:0]         fac_abs;
    logic signed [tcsg_pkg::CLS_W-1:0]  row_x, top_x, bottom_x;
    logic                               is_floor, is_ceil, is_wall;
    logic [tcsg_pkg::DIVR_W:0]          trial, trial_diff;
    logic                               trial_ge;
    logic [STEP_W-1:0]                  dividend;
    logic signed [POS_W-1:0]            step_ext;
    logic [POS_W-1:0]                   abs_pos;
    logic [tcsg_pkg::DIVR_W-1:0]        h_ext, texel_full;
    logic                               out_busy;

    // ---------------------------------------------------------------- configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[tcsg_pkg::ADDR_W-1:2];

    always_comb begin
        case (cfg_index)
            tcsg_pkg::REG_CEILING:    prdata = ceiling_reg;
            tcsg_pkg::REG_FLOOR:      prdata = floor_reg;
            tcsg_pkg::REG_PLAIN:      prdata = plain_reg;
            tcsg_pkg::REG_ROWS:       prdata = tcsg_pkg::DATA_W'(rows_reg);
            tcsg_pkg::REG_HORIZON:    prdata = tcsg_pkg::DATA_W'(horizon_reg);
            tcsg_pkg::REG_TEX_HEIGHT: prdata = tcsg_pkg::DATA_W'(tex_height_reg);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg    <= '0;
            floor_reg      <= '0;
            plain_reg      <= 32'h00FF_0000;
            rows_reg       <= 12'd480;
            horizon_reg    <= 11'd240;
            tex_height_reg <= 11'd64;
        end else if (cfg_write) begin
            case (cfg_index)
                tcsg_pkg::REG_CEILING:    ceiling_reg    <= pwdata;
                tcsg_pkg::REG_FLOOR:      floor_reg      <= pwdata;
                tcsg_pkg::REG_PLAIN:      plain_reg      <= pwdata;
                tcsg_pkg::REG_ROWS:       rows_reg       <= pwdata[tcsg_pkg::ROWS_W-1:0];
                tcsg_pkg::REG_HORIZON:    horizon_reg    <= pwdata[tcsg_pkg::HOR_W-1:0];
                tcsg_pkg::REG_TEX_HEIGHT: tex_height_reg <= pwdata[tcsg_pkg::H_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    tcsg_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uword   (uword)
    );

    // ---------------------------------------------------------------- derived values
    assign h_eff = (tex_height_reg > tcsg_pkg::H_W'(tcsg_pkg::TEX_MAX))
                 ? tcsg_pkg::H_W'(tcsg_pkg::TEX_MAX) : tex_height_reg;

    assign rows_raw = RW'(rows_reg);
    assign rows_lim = RW'(1) << ROW_BITS;
    assign rows_eff = (rows_raw == '0) ? RW'(1)
                    : ((rows_raw > rows_lim) ? rows_lim : rows_raw);
    assign last_row = (RW'(row_reg) + RW'(1)) >= rows_eff;

    assign span     = {bottom_reg[tcsg_pkg::SPAN_W-1], bottom_reg}
                    - {top_reg[tcsg_pkg::SPAN_W-1], top_reg};
    assign span_pos = !span[tcsg_pkg::SPAN_W] && (span != '0);

    // The start position folds the advance to row 0 into the factor: a wall that begins
    // above the screen starts its count at row 0 instead of at its top.
    assign top_clip = top_reg[tcsg_pkg::SPAN_W-1] ? '0
                    : $signed({{(tcsg_pkg::FAC_W - tcsg_pkg::SPAN_W){1'b0}}, top_reg});
    assign fac      = top_clip
                    - $signed({{(tcsg_pkg::FAC_W - tcsg_pkg::HOR_W){1'b0}}, horizon_reg})
                    + $signed({{(tcsg_pkg::FAC_W - tcsg_pkg::SPAN_W - 1){span[tcsg_pkg::SPAN_W]}},
                               span >>> 1});
    assign fac_abs  = fac[tcsg_pkg::FAC_W-1] ? -fac : fac;

    assign row_x    = $signed({{(tcsg_pkg::CLS_W - ROW_BITS){1'b0}}, row_reg});
    assign top_x    = $signed({{(tcsg_pkg::CLS_W - tcsg_pkg::SPAN_W){top_reg[tcsg_pkg::SPAN_W-1]}},
                               top_reg});
    assign bottom_x = $signed({{(tcsg_pkg::CLS_W - tcsg_pkg::SPAN_W){bottom_reg[tcsg_pkg::SPAN_W-1]}},
                               bottom_reg});
    assign is_floor = row_x >= bottom_x;
    assign is_ceil  = !is_floor && (row_x < top_x);
    assign is_wall  = !is_floor && !is_ceil;

    assign trial      = {rem_reg, shift_reg[SH_W-1]};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign trial_ge   = trial >= {1'b0, divisor_reg};

    assign dividend = STEP_W'(h_eff) << FRAC_BITS;
    assign step_ext = $signed(POS_W'(step_reg));
    assign abs_pos  = pos_reg[POS_W-1] ? -pos_reg : pos_reg;

    // The position is truncated toward zero, so a negative one takes the complement of its
    // remainder to land in the texture.
    assign h_ext      = {{(tcsg_pkg::DIVR_W - tcsg_pkg::H_W){1'b0}}, h_eff};
    assign texel_full = (h_eff == '0) ? '0
                      : ((neg_reg && rem_reg != '0) ? h_ext - rem_reg : rem_reg);

    assign out_busy = m_valid_reg && !m_ready;

    assign flags.no_beat  = !s_valid;
    assign flags.pixel    = (kind_reg == tcsg_pkg::KIND_PIXEL);
    assign flags.no_span  = !span_pos || (h_eff == '0);
    assign flags.more     = (cnt_reg != CNT_W'(1));
    assign flags.idle_col = !active_reg;
    assign flags.no_fetch = !(is_wall && textured_reg);
    assign flags.out_busy = out_busy;

    assign s_ready = (uword.op == tcsg_pkg::OP_ACCEPT);

    // ---------------------------------------------------------------- datapath
    always_comb begin
        active_next   = active_reg;
        row_next      = row_reg;
        kind_next     = kind_reg;
        column_next   = column_reg;
        top_next      = top_reg;
        bottom_next   = bottom_reg;
        texcol_next   = texcol_reg;
        textured_next = textured_reg;
        step_next     = step_reg;
        pos_next      = pos_reg;
        shift_next    = shift_reg;
        rem_next      = rem_reg;
        divisor_next  = divisor_reg;
        cnt_next      = cnt_reg;
        neg_next      = neg_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_column_next = m_column_reg;
        m_row_next    = m_row_reg;
        m_source_next = m_source_reg;
        m_colour_next = m_colour_reg;
        m_trow_next   = m_trow_reg;
        m_tcol_next   = m_tcol_reg;
        m_last_next   = m_last_reg;

        case (uword.op)
            tcsg_pkg::OP_ACCEPT: begin
                if (s_valid) begin
                    kind_next = s_kind;
                    if (s_kind == tcsg_pkg::KIND_START) begin
                        column_next   = s_column;
                        top_next      = s_wall_top;
                        bottom_next   = s_wall_bottom;
                        texcol_next   = s_texture_column;
                        textured_next = s_textured;
                        row_next      = '0;
                        active_next   = 1'b1;
                    end
                end
            end
            tcsg_pkg::OP_DIV_LOAD: begin
                shift_next   = SH_W'(dividend) << (SH_W - STEP_W);
                rem_next     = '0;
                divisor_next = span[tcsg_pkg::DIVR_W-1:0];
                cnt_next     = CNT_W'(STEP_W);
            end
            tcsg_pkg::OP_DIV_STEP, tcsg_pkg::OP_MOD_STEP: begin
                rem_next   = trial_ge ? trial_diff[tcsg_pkg::DIVR_W-1:0]
                                      : trial[tcsg_pkg::DIVR_W-1:0];
                shift_next = {shift_reg[SH_W-2:0], trial_ge};
                cnt_next   = cnt_reg - 1'b1;
            end
            tcsg_pkg::OP_MUL_LOAD: begin
                step_next  = shift_reg[STEP_W-1:0];
                shift_next = SH_W'(fac_abs[tcsg_pkg::MAG_W-1:0]) << (SH_W - tcsg_pkg::MAG_W);
                pos_next   = '0;
                neg_next   = fac[tcsg_pkg::FAC_W-1];
                cnt_next   = CNT_W'(tcsg_pkg::MAG_W);
            end
            tcsg_pkg::OP_MUL_STEP: begin
                pos_next   = (pos_reg <<< 1) + (shift_reg[SH_W-1] ? step_ext : '0);
                shift_next = shift_reg << 1;
                cnt_next   = cnt_reg - 1'b1;
            end
            tcsg_pkg::OP_MUL_FIX: begin
                if (neg_reg) begin
                    pos_next = -pos_reg;
                end
            end
            tcsg_pkg::OP_CLEAR: begin
                step_next = '0;
                pos_next  = '0;
            end
            tcsg_pkg::OP_MOD_LOAD: begin
                shift_next   = SH_W'(abs_pos[POS_W-2:FRAC_BITS]) << (SH_W - TI_W);
                rem_next     = '0;
                divisor_next = h_ext;
                neg_next     = pos_reg[POS_W-1];
                cnt_next     = CNT_W'(TI_W);
            end
            tcsg_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    m_valid_next  = 1'b1;
                    m_column_next = column_reg;
                    m_row_next    = row_reg;
                    m_last_next   = last_row;
                    m_trow_next   = '0;
                    m_tcol_next   = '0;
                    if (is_floor) begin
                        m_source_next = tcsg_pkg::SRC_FLOOR;
                        m_colour_next = floor_reg;
                    end else if (is_ceil) begin
                        m_source_next = tcsg_pkg::SRC_CEILING;
                        m_colour_next = ceiling_reg;
                    end else begin
                        if (textured_reg) begin
                            m_source_next = tcsg_pkg::SRC_TEXTURE;
                            m_colour_next = '0;
                            m_trow_next   = texel_full[tcsg_pkg::TROW_W-1:0];
                            m_tcol_next   = texcol_reg;
                        end else begin
                            m_source_next = tcsg_pkg::SRC_PLAIN;
                            m_colour_next = plain_reg;
                        end
                        pos_next = pos_reg + step_ext;
                    end
                    if (last_row) begin
                        active_next = 1'b0;
                        row_next    = '0;
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            row_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            row_reg     <= row_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg      <= kind_next;
        column_reg    <= column_next;
        top_reg       <= top_next;
        bottom_reg    <= bottom_next;
        texcol_reg    <= texcol_next;
        textured_reg  <= textured_next;
        step_reg      <= step_next;
        pos_reg       <= pos_next;
        shift_reg     <= shift_next;
        rem_reg       <= rem_next;
        divisor_reg   <= divisor_next;
        cnt_reg       <= cnt_next;
        neg_reg       <= neg_next;
        m_column_reg  <= m_column_next;
        m_row_reg     <= m_row_next;
        m_source_reg  <= m_source_next;
        m_colour_reg  <= m_colour_next;
        m_trow_reg    <= m_trow_next;
        m_tcol_reg    <= m_tcol_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_column = m_column_reg;
    assign m_pixel_row    = m_row_reg;
    assign m_source       = m_source_reg;
    assign m_colour       = m_colour_reg;
    assign m_texel_row    = m_trow_reg;
    assign m_texel_column = m_tcol_reg;
    assign m_last         = m_last_reg;

endmodule

`default_nettype wire

FILE: bench/textured_column_span_generator_core_tb.sv
// Self-checking testbench for the textured wall column span generator core.
// Drives start and pixel beats plus APB register writes; depends on tcsg_pkg and the core RTL.
`timescale 1ns / 1ps

module textured_column_span_generator_core_tb;

    localparam int ROW_BITS  = 11;
    localparam int COL_BITS  = 11;
    localparam int FRAC_BITS = 16;
    // Long enough to cover the work of a start beat and of a textured pixel.
    localparam int DRAIN     = 100;
    localparam int HOLD_LEN  = 400;
    localparam int PHASES    = 12;
    localparam int PHASE_BEATS = 72;

    localparam logic [31:0] CEIL_D  = 32'hFFFF_FFFF;
    localparam logic [31:0] FLOOR_D = 32'hA5A5_A5A5;
    localparam logic [31:0] PLAIN_D = 32'h5A5A_5A5A;

    typedef struct packed {
        logic                          kind;
        logic [COL_BITS-1:0]           column;
        logic [tcsg_pkg::SPAN_W-1:0]   top;
        logic [tcsg_pkg::SPAN_W-1:0]   bottom;
        logic [tcsg_pkg::TCOL_W-1:0]   tcol;
        logic                          textured;
    } beat_t;

    typedef struct packed {
        logic [COL_BITS-1:0]           pcol;
        logic [ROW_BITS-1:0]           prow;
        logic [tcsg_pkg::SRC_W-1:0]    src;
        logic [tcsg_pkg::COLOUR_W-1:0] colour;
        logic [tcsg_pkg::TROW_W-1:0]   trow;
        logic [tcsg_pkg::TCOL_W-1:0]   tcol;
        logic                          last;
    } pixel_t;

    typedef struct packed {
        logic                        is_cfg;
        logic [tcsg_pkg::IDX_W-1:0]  reg_idx;
        logic [tcsg_pkg::DATA_W-1:0] value;
        beat_t                       beat;
        logic                        typed;
        logic                        t_emits;
        pixel_t                      t_px;
    } step_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [tcsg_pkg::ADDR_W-1:0] paddr = '0;
    logic [tcsg_pkg::DATA_W-1:0] pwdata = '0;
    logic [tcsg_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic                               s_kind = 1'b0;
    logic [COL_BITS-1:0]                s_column = '0;
    logic signed [tcsg_pkg::SPAN_W-1:0] s_wall_top = '0;
    logic signed [tcsg_pkg::SPAN_W-1:0] s_wall_bottom = '0;
    logic [tcsg_pkg::TCOL_W-1:0]        s_texture_column = '0;
    logic                               s_textured = 1'b0;

    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [COL_BITS-1:0]           m_pixel_column;
    logic [ROW_BITS-1:0]           m_pixel_row;
    logic [tcsg_pkg::SRC_W-1:0]    m_source;
    logic [tcsg_pkg::COLOUR_W-1:0] m_colour;
    logic [tcsg_pkg::TROW_W-1:0]   m_texel_row;
    logic [tcsg_pkg::TCOL_W-1:0]   m_texel_column;
    logic                          m_last;

    textured_column_span_generator_core #(
        .ROW_BITS (ROW_BITS),
        .COL_BITS (COL_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_column        (s_column),
        .s_wall_top      (s_wall_top),
        .s_wall_bottom   (s_wall_bottom),
        .s_texture_column(s_texture_column),
        .s_textured      (s_textured),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_column  (m_pixel_column),
        .m_pixel_row     (m_pixel_row),
        .m_source        (m_source),
        .m_colour        (m_colour),
        .m_texel_row     (m_texel_row),
        .m_texel_column  (m_texel_column),
        .m_last          (m_last)
    );

    always #4 aclk = ~aclk;

    // Register shadow, starting from the reset values.
    logic [tcsg_pkg::COLOUR_W-1:0] ceil_rgb = '0;
    logic [tcsg_pkg::COLOUR_W-1:0] floor_rgb = '0;
    logic [tcsg_pkg::COLOUR_W-1:0] plain_rgb = 32'h00FF_0000;
    logic [tcsg_pkg::ROWS_W-1:0]   rows_reg = 12'd480;
    logic [tcsg_pkg::HOR_W-1:0]    horizon_reg = 11'd240;
    logic [tcsg_pkg::H_W-1:0]      theight_reg = 11'd64;

    // Column walker state.
    bit     col_live = 1'b0;
    int     col_index = 0;
    int     row_index = 0;
    int     top_r = 0;
    int     bot_r = 0;
    int     slice_col = 0;
    bit     slice_tex = 1'b0;
    longint tex_pos = 0;
    longint tex_inc = 0;

    pixel_t expected_pixels[$];
    step_t  script[$];

    int  mismatches = 0;
    int  pixels_checked = 0;
    int  beats_sent = 0;
    int  settings_used = 0;
    bit  no_idle = 1'b0;
    bit  hold_request = 1'b0;
    int  hold_left = 0;

    function automatic int screen_rows_eff();
        if (rows_reg == 0)
            return 1;
        return (rows_reg > 2048) ? 2048 : int'(rows_reg);
    endfunction

    function automatic int tex_rows_eff();
        return (theight_reg > tcsg_pkg::TEX_MAX) ? tcsg_pkg::TEX_MAX : int'(theight_reg);
    endfunction

    // Integer part truncated toward zero, then wrapped into 0 .. h-1.
    function automatic int texel_row_of(input longint pos, input int h);
        longint whole;
        longint m;
        if (h == 0)
            return 0;
        whole = (pos < 0) ? -((-pos) >>> FRAC_BITS) : (pos >>> FRAC_BITS);
        if (whole >= 0)
            return int'(whole % h);
        m = (-whole) % h;
        return (m == 0) ? 0 : h - int'(m);
    endfunction

    task automatic column_walk(input beat_t b, output bit emits, output pixel_t px);
        int span;
        int h;
        emits = 1'b0;
        px = '0;
        if (b.kind == tcsg_pkg::KIND_START) begin
            col_index = int'(b.column);
            top_r = int'($signed(b.top));
            bot_r = int'($signed(b.bottom));
            slice_col = int'(b.tcol);
            slice_tex = b.textured;
            row_index = 0;
            col_live = 1'b1;
            span = bot_r - top_r;
            h = tex_rows_eff();
            if (span > 0 && h > 0) begin
                tex_inc = (longint'(h) << FRAC_BITS) / span;
                tex_pos = longint'(top_r - int'(horizon_reg) + span / 2) * tex_inc;
                // Rows above the screen are skipped, so advance the position to row 0.
                if (top_r < 0)
                    tex_pos += longint'(-top_r) * tex_inc;
            end else begin
                tex_inc = 0;
                tex_pos = 0;
            end
        end else if (col_live) begin
            emits = 1'b1;
            px.pcol = COL_BITS'(col_index);
            px.prow = ROW_BITS'(row_index);
            if (row_index >= bot_r) begin
                px.src = tcsg_pkg::SRC_FLOOR;
                px.colour = floor_rgb;
            end else if (row_index < top_r) begin
                px.src = tcsg_pkg::SRC_CEILING;
                px.colour = ceil_rgb;
            end else begin
                if (slice_tex) begin
                    px.src = tcsg_pkg::SRC_TEXTURE;
                    px.trow = tcsg_pkg::TROW_W'(texel_row_of(tex_pos, tex_rows_eff()));
                    px.tcol = tcsg_pkg::TCOL_W'(slice_col);
                end else begin
                    px.src = tcsg_pkg::SRC_PLAIN;
                    px.colour = plain_rgb;
                end
                tex_pos += tex_inc;
            end
            px.last = (row_index + 1 >= screen_rows_eff());
            if (px.last) begin
                col_live = 1'b0;
                row_index = 0;
            end else begin
                row_index++;
            end
        end
    endtask

    function automatic beat_t start_beat(input int col, input int top, input int bot,
                                         input int tcol, input bit tex);
        beat_t b;
        b.kind = tcsg_pkg::KIND_START;
        b.column = COL_BITS'(col);
        b.top = tcsg_pkg::SPAN_W'(top);
        b.bottom = tcsg_pkg::SPAN_W'(bot);
        b.tcol = tcsg_pkg::TCOL_W'(tcol);
        b.textured = tex;
        return b;
    endfunction

    // The start fields are ignored on a pixel beat, so they carry noise.
    function automatic beat_t pixel_beat();
        beat_t b;
        b.kind = tcsg_pkg::KIND_PIXEL;
        b.column = COL_BITS'($urandom);
        b.top = tcsg_pkg::SPAN_W'($urandom);
        b.bottom = tcsg_pkg::SPAN_W'($urandom);
        b.tcol = tcsg_pkg::TCOL_W'($urandom);
        b.textured = 1'($urandom);
        return b;
    endfunction

    function automatic pixel_t pix(input int col, input int row,
                                   input logic [tcsg_pkg::SRC_W-1:0] src,
                                   input logic [31:0] colour, input int trow, input int tcol,
                                   input bit last);
        pixel_t p;
        p.pcol = COL_BITS'(col);
        p.prow = ROW_BITS'(row);
        p.src = src;
        p.colour = colour;
        p.trow = tcsg_pkg::TROW_W'(trow);
        p.tcol = tcsg_pkg::TCOL_W'(tcol);
        p.last = last;
        return p;
    endfunction

    task automatic cfg_row(input logic [tcsg_pkg::IDX_W-1:0] idx,
                           input logic [tcsg_pkg::DATA_W-1:0] val);
        step_t e;
        e = '0;
        e.is_cfg = 1'b1;
        e.reg_idx = idx;
        e.value = val;
        script.push_back(e);
    endtask

    task automatic beat_row(input beat_t b);
        step_t e;
        e = '0;
        e.beat = b;
        script.push_back(e);
    endtask

    task automatic typed_row(input beat_t b, input bit emits, input pixel_t px);
        step_t e;
        e = '0;
        e.beat = b;
        e.typed = 1'b1;
        e.t_emits = emits;
        e.t_px = px;
        script.push_back(e);
    endtask

    // Offers one beat, waits for its handshake and records what it should produce.
    task automatic offer(input beat_t b, input bit typed, input bit t_emits, input pixel_t t_px);
        bit     emits;
        pixel_t px;
        if (!no_idle) begin
            while ($urandom_range(0, 99) < 19) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_kind <= b.kind;
        s_column <= b.column;
        s_wall_top <= b.top;
        s_wall_bottom <= b.bottom;
        s_texture_column <= b.tcol;
        s_textured <= b.textured;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        column_walk(b, emits, px);
        if (typed) begin
            emits = t_emits;
            px = t_px;
        end
        if (emits)
            expected_pixels.push_back(px);
    endtask

    // Brings the block to rest before a register write.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tcsg_pkg::IDX_W-1:0] idx,
                             input logic [tcsg_pkg::DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        case (idx)
            tcsg_pkg::REG_CEILING:    ceil_rgb = val;
            tcsg_pkg::REG_FLOOR:      floor_rgb = val;
            tcsg_pkg::REG_PLAIN:      plain_rgb = val;
            tcsg_pkg::REG_ROWS:       rows_reg = val[tcsg_pkg::ROWS_W-1:0];
            tcsg_pkg::REG_HORIZON:    horizon_reg = val[tcsg_pkg::HOR_W-1:0];
            tcsg_pkg::REG_TEX_HEIGHT: theight_reg = val[tcsg_pkg::H_W-1:0];
            default: ;
        endcase
    endtask

    // Result side: random back-pressure plus the occasional long hold-off.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_LEN;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && (no_idle || $urandom_range(0, 99) >= 19);
        end
    end

    always @(posedge aclk) begin : pixel_check
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected pixel beat: column %0d row %0d", m_pixel_column, m_pixel_row);
                mismatches++;
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (m_pixel_column !== want.pcol) begin
                    $error("pixel_column: expected %0d, got %0d", want.pcol, m_pixel_column);
                    mismatches++;
                end
                if (m_pixel_row !== want.prow) begin
                    $error("pixel_row: expected %0d, got %0d", want.prow, m_pixel_row);
                    mismatches++;
                end
                if (m_source !== want.src) begin
                    $error("source: expected %0d, got %0d", want.src, m_source);
                    mismatches++;
                end
                if (m_colour !== want.colour) begin
                    $error("colour: expected %h, got %h", want.colour, m_colour);
                    mismatches++;
                end
                if (m_texel_row !== want.trow) begin
                    $error("texel_row: expected %0d, got %0d", want.trow, m_texel_row);
                    mismatches++;
                end
                if (m_texel_column !== want.tcol) begin
                    $error("texel_column: expected %0d, got %0d", want.tcol, m_texel_column);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        pixel_t none;
        beat_t  b;
        int     n;
        int     eff;
        int     near;
        int     npix;
        int     t;
        int     bt;
        int     rows;
        int     hz;
        int     th;
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] c2;

        none = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, first under the reset register values.
        typed_row(pixel_beat(), 1'b0, none);
        beat_row(start_beat(2047, -4096, 4095, 0, 1'b0));
        typed_row(pixel_beat(), 1'b1,
                  pix(2047, 0, tcsg_pkg::SRC_PLAIN, 32'h00FF_0000, 0, 0, 1'b0));
        cfg_row(tcsg_pkg::REG_CEILING, CEIL_D);
        cfg_row(tcsg_pkg::REG_FLOOR, FLOOR_D);
        cfg_row(tcsg_pkg::REG_PLAIN, PLAIN_D);
        cfg_row(tcsg_pkg::REG_ROWS, 4);
        cfg_row(tcsg_pkg::REG_HORIZON, 0);
        cfg_row(tcsg_pkg::REG_TEX_HEIGHT, 1024);
        // A two-row textured wall in a four-row column.
        beat_row(start_beat(0, 1, 3, 1023, 1'b1));
        typed_row(pixel_beat(), 1'b1, pix(0, 0, tcsg_pkg::SRC_CEILING, CEIL_D, 0, 0, 1'b0));
        beat_row(pixel_beat());
        beat_row(pixel_beat());
        typed_row(pixel_beat(), 1'b1, pix(0, 3, tcsg_pkg::SRC_FLOOR, FLOOR_D, 0, 0, 1'b1));
        typed_row(pixel_beat(), 1'b0, none);
        // Empty span: no wall rows at all.
        beat_row(start_beat(5, 3, 3, 0, 1'b1));
        repeat (4) beat_row(pixel_beat());
        // Wall starting above the screen, cut short by the next start.
        beat_row(start_beat(1024, -5, 2, 10'h155, 1'b1));
        repeat (2) beat_row(pixel_beat());
        // Negative span: every row lies at or below the bottom.
        beat_row(start_beat(1, 4095, -4096, 0, 1'b0));
        typed_row(pixel_beat(), 1'b1, pix(1, 0, tcsg_pkg::SRC_FLOOR, FLOOR_D, 0, 0, 1'b0));
        cfg_row(tcsg_pkg::REG_TEX_HEIGHT, 0);
        beat_row(start_beat(2, 0, 4, 10'h2AA, 1'b1));
        typed_row(pixel_beat(), 1'b1,
                  pix(2, 0, tcsg_pkg::SRC_TEXTURE, 32'h0, 0, 10'h2AA, 1'b0));
        // Zero rows acts as one row; oversized texture height saturates.
        cfg_row(tcsg_pkg::REG_ROWS, 0);
        cfg_row(tcsg_pkg::REG_TEX_HEIGHT, 2047);
        cfg_row(tcsg_pkg::REG_HORIZON, 2047);
        beat_row(start_beat(3, -4096, -4095, 1023, 1'b1));
        typed_row(pixel_beat(), 1'b1, pix(3, 0, tcsg_pkg::SRC_FLOOR, FLOOR_D, 0, 0, 1'b1));
        beat_row(start_beat(4, 0, 4095, 0, 1'b1));
        beat_row(pixel_beat());

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].reg_idx, script[i].value);
            end else begin
                offer(script[i].beat, script[i].typed, script[i].t_emits, script[i].t_px);
            end
        end

        // Random part: one register setting per phase, then columns with random content.
        for (int ph = 0; ph < PHASES; ph++) begin
            c0 = $urandom;
            c1 = $urandom;
            c2 = $urandom;
            case (ph)
                0: begin
                    rows = 2048; hz = 2047; th = 1024; c0 = 32'h0; c1 = 32'hFFFF_FFFF;
                end
                1: begin
                    rows = 1; hz = 0; th = 1;
                end
                2: begin
                    rows = 4095; hz = $urandom_range(0, 2047); th = 2047;
                end
                3: begin
                    rows = 0; hz = $urandom_range(0, 16); th = 0;
                end
                default: begin
                    rows = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                       : $urandom_range(1, 24);
                    hz = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                     : $urandom_range(0, rows);
                    th = ($urandom_range(0, 7) == 0) ? $urandom_range(1025, 2047)
                                                     : $urandom_range(1, 1024);
                end
            endcase
            settle();
            write_reg(tcsg_pkg::REG_CEILING, c0);
            write_reg(tcsg_pkg::REG_FLOOR, c1);
            write_reg(tcsg_pkg::REG_PLAIN, c2);
            write_reg(tcsg_pkg::REG_ROWS, rows);
            write_reg(tcsg_pkg::REG_HORIZON, hz);
            write_reg(tcsg_pkg::REG_TEX_HEIGHT, th);
            settings_used++;
            no_idle = (ph == 6);
            if (ph == 4 || ph == 9)
                hold_request = 1'b1;

            n = 0;
            while (n < PHASE_BEATS) begin
                if ($urandom_range(0, 99) < 6) begin
                    offer(pixel_beat(), 1'b0, 1'b0, none);
                    n++;
                end
                eff = screen_rows_eff();
                near = (eff < 48) ? eff : 48;
                if ($urandom_range(0, 9) < 7) begin
                    t = $urandom_range(0, near + 16);
                    t = t - 8;
                    bt = $urandom_range(0, near + 8);
                    bt = t + bt - 2;
                end else begin
                    t = $urandom_range(0, 8191);
                    t = t - 4096;
                    bt = $urandom_range(0, 8191);
                    bt = bt - 4096;
                end
                b = start_beat($urandom_range(0, 2047), t, bt, $urandom_range(0, 1023),
                               1'($urandom));
                offer(b, 1'b0, 1'b0, none);
                n++;
                // Short columns mostly run to their last row; others are usually cut by the next start.
                if ($urandom_range(0, 99) < 80 && eff <= 64)
                    npix = eff;
                else
                    npix = $urandom_range(1, (eff < 40) ? eff : 40);
                repeat (npix) offer(pixel_beat(), 1'b0, 1'b0, none);
                n += npix;
            end
        end
        no_idle = 1'b0;

        settle();
        $display("Sent %0d beats and checked %0d pixels over %0d random register settings,",
                 beats_sent, pixels_checked, settings_used);
        $display("including empty and inverted spans, saturated heights and long output stalls.");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #8ms;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
rtl/tcsg_pkg.sv
rtl/tcsg_sequencer.sv
rtl/textured_column_span_generator_core.sv
bench/textured_column_span_generator_core_tb.sv
